/* design/tbseq_pkg.sv */
// Shared types, constants and register codes for the three-band stereo equalizer.
// No dependencies; every other design file imports this package.
package tbseq_pkg;

  // block configuration
  localparam int KNOB_MAX    = 4095;
  localparam int KNOB_CENTER = 2048;
  localparam int GAIN_HOLD   = 32;
  localparam int SAMPLE_BITS = 16;

  // field and state widths
  localparam int PCM_W      = 16;
  localparam int ALPHA_W    = 16;
  localparam int KNOB_W     = 12;
  localparam int GAIN_W     = 17;
  localparam int HOLD_W     = 6;
  localparam int STATE_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // datapath widths
  localparam int OPA_W  = STATE_W + 1;
  localparam int OPB_W  = GAIN_W + 1;
  localparam int PROD_W = OPA_W + OPB_W;
  localparam int ACC_W  = PROD_W + 2;

  // gain divider widths
  localparam int NUM_W = KNOB_W + 16;
  localparam int DEN_W = 16;
  localparam int UPPER_DEN = (KNOB_MAX > KNOB_CENTER) ? (KNOB_MAX - KNOB_CENTER) : 1;

  // reset values
  localparam int UNITY_GAIN      = 32768;
  localparam int LOW_COEF_RESET  = 6705;
  localparam int HIGH_COEF_RESET = 23791;
  localparam int KNOB_RESET      = (2048 > KNOB_MAX) ? KNOB_MAX : 2048;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOW_COEF  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_COEF = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KNOB_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KNOB_MID  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KNOB_HIGH = 3'd4;

  // lane sequence steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_LOW_ONE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LOW_TWO   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_HIGH_ONE  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_HIGH_TWO  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_LOW_BAND  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_MID_BAND  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_HIGH_BAND = 3'd6;

  typedef struct packed {
    logic signed [PCM_W-1:0] left_in;
    logic signed [PCM_W-1:0] right_in;
  } sample_t;

  typedef struct packed {
    logic signed [PCM_W-1:0] left_out;
    logic signed [PCM_W-1:0] right_out;
  } result_t;

  typedef struct packed {
    logic              load;
    logic              mul_en;
    logic              upd_en;
    logic [STEP_W-1:0] step;
  } lane_ctrl_t;

endpackage

/* design/tbseq_gain.sv */
// Knob to band gain conversion by multiplying with a constant reciprocal,
// registered after start and flagged by done. Depends on tbseq_pkg.
module tbseq_gain import tbseq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [KNOB_W-1:0] knob,
  output logic [GAIN_W-1:0] gain,
  output logic              done
);

  // floor(n / d) == (n * ceil(2^s / d)) >> s for every n below 2^NUM_W
  localparam int     SHIFT_CTR = NUM_W + $clog2(KNOB_CENTER);
  localparam int     SHIFT_UP  = NUM_W + $clog2(UPPER_DEN);
  localparam longint RECIP_CTR = ((64'sd1 <<< SHIFT_CTR) + longint'(KNOB_CENTER) - 64'sd1) /
                                 longint'(KNOB_CENTER);
  localparam longint RECIP_UP  = ((64'sd1 <<< SHIFT_UP) + longint'(UPPER_DEN) - 64'sd1) /
                                 longint'(UPPER_DEN);
  localparam int     RECIP_W   = NUM_W + 2;
  localparam int     QPROD_W   = NUM_W + RECIP_W;

  logic               busy;
  logic               upper;
  logic [NUM_W-1:0]   numq;
  logic [QPROD_W-1:0] qprod;

  logic               upper_next;
  logic [16:0]        knob_ext;
  logic [16:0]        diff;
  logic [NUM_W-1:0]   num_next;
  logic [RECIP_W-1:0] recip;
  logic [QPROD_W-1:0] quot;

  always_comb begin
    knob_ext   = 17'(knob);
    diff       = knob_ext - 17'(KNOB_CENTER);
    upper_next = (KNOB_MAX > KNOB_CENTER) && (knob_ext > 17'(KNOB_CENTER));
    if (upper_next) begin
      num_next = NUM_W'({diff[KNOB_W-1:0], 15'd0}) + NUM_W'(UPPER_DEN / 2);
    end else begin
      num_next = NUM_W'({knob, 15'd0}) + NUM_W'(KNOB_CENTER / 2);
    end
    recip = upper ? RECIP_W'(RECIP_UP) : RECIP_W'(RECIP_CTR);
    quot  = upper ? (qprod >> SHIFT_UP) : (qprod >> SHIFT_CTR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      numq  <= num_next;
      upper <= upper_next;
    end
    if (busy) begin
      qprod <= QPROD_W'(numq) * QPROD_W'(recip);
    end
  end

  assign gain = GAIN_W'(quot) + (upper ? GAIN_W'(UNITY_GAIN) : GAIN_W'(0));

endmodule

/* design/tbseq_lane.sv */
// One channel lane: crossover filter states and a shared multiplier that
// runs the four pole updates and the three band weightings. Depends on tbseq_pkg.
module tbseq_lane import tbseq_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  lane_ctrl_t              ctrl,
  input  logic signed [PCM_W-1:0] sample,
  input  logic [ALPHA_W-1:0]      low_coef,
  input  logic [ALPHA_W-1:0]      high_coef,
  input  logic [GAIN_W-1:0]       gain_low,
  input  logic [GAIN_W-1:0]       gain_mid,
  input  logic [GAIN_W-1:0]       gain_high,
  output logic signed [ACC_W-1:0] acc
);

  localparam int SUM_W = PROD_W + 1;
  localparam logic signed [PROD_W-1:0] HALF_LSB = PROD_W'(32768);
  localparam logic signed [SUM_W-1:0]  SAT_HI = SUM_W'((64'sd1 <<< 31) - 64'sd1);
  localparam logic signed [SUM_W-1:0]  SAT_LO = SUM_W'(-(64'sd1 <<< 31));

  logic signed [STATE_W-1:0] x;
  logic signed [STATE_W-1:0] low_one;
  logic signed [STATE_W-1:0] low_two;
  logic signed [STATE_W-1:0] high_one;
  logic signed [STATE_W-1:0] high_two;
  logic signed [PROD_W-1:0]  prod;

  logic signed [OPA_W-1:0]   op_a;
  logic signed [OPB_W-1:0]   op_b;
  logic signed [STATE_W-1:0] y;
  logic signed [PROD_W-1:0]  rnd;
  logic signed [SUM_W-1:0]   pole_sum;
  logic signed [STATE_W-1:0] pole_new;

  always_comb begin
    op_a = '0;
    op_b = '0;
    y    = '0;
    case (ctrl.step)
      STEP_LOW_ONE: begin
        op_a = {x[STATE_W-1], x} - {low_one[STATE_W-1], low_one};
        op_b = {2'b00, low_coef};
        y    = low_one;
      end
      STEP_LOW_TWO: begin
        op_a = {low_one[STATE_W-1], low_one} - {low_two[STATE_W-1], low_two};
        op_b = {2'b00, low_coef};
        y    = low_two;
      end
      STEP_HIGH_ONE: begin
        op_a = {x[STATE_W-1], x} - {high_one[STATE_W-1], high_one};
        op_b = {2'b00, high_coef};
        y    = high_one;
      end
      STEP_HIGH_TWO: begin
        op_a = {high_one[STATE_W-1], high_one} - {high_two[STATE_W-1], high_two};
        op_b = {2'b00, high_coef};
        y    = high_two;
      end
      STEP_LOW_BAND: begin
        op_a = {low_two[STATE_W-1], low_two};
        op_b = {1'b0, gain_low};
      end
      // mid band is the high cascade minus the low cascade
      STEP_MID_BAND: begin
        op_a = {high_two[STATE_W-1], high_two} - {low_two[STATE_W-1], low_two};
        op_b = {1'b0, gain_mid};
      end
      STEP_HIGH_BAND: begin
        op_a = {x[STATE_W-1], x} - {high_two[STATE_W-1], high_two};
        op_b = {1'b0, gain_high};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase

    // round half up, then floor
    rnd      = (prod + HALF_LSB) >>> 16;
    pole_sum = {{(SUM_W - STATE_W){y[STATE_W-1]}}, y} + {rnd[PROD_W-1], rnd};
    if (pole_sum > SAT_HI) begin
      pole_new = SAT_HI[STATE_W-1:0];
    end else if (pole_sum < SAT_LO) begin
      pole_new = SAT_LO[STATE_W-1:0];
    end else begin
      pole_new = pole_sum[STATE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      low_one  <= '0;
      low_two  <= '0;
      high_one <= '0;
      high_two <= '0;
    end else if (ctrl.upd_en) begin
      case (ctrl.step)
        STEP_LOW_ONE:  low_one  <= pole_new;
        STEP_LOW_TWO:  low_two  <= pole_new;
        STEP_HIGH_ONE: high_one <= pole_new;
        STEP_HIGH_TWO: high_two <= pole_new;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x   <= {sample, 16'd0};
      acc <= '0;
    end else if (ctrl.upd_en && ctrl.step inside {STEP_LOW_BAND, STEP_MID_BAND,
                                                  STEP_HIGH_BAND}) begin
      acc <= acc + {{2{prod[PROD_W-1]}}, prod};
    end
    if (ctrl.mul_en) begin
      prod <= PROD_W'(op_a) * PROD_W'(op_b);
    end
  end

endmodule

/* design/tbseq_merge.sv */
// Merges the two lane sums into one result: round, saturate, pack.
// Depends on tbseq_pkg.
module tbseq_merge import tbseq_pkg::*; (
  input  logic signed [ACC_W-1:0] acc_left,
  input  logic signed [ACC_W-1:0] acc_right,
  output result_t                 merged
);

  localparam logic signed [ACC_W-1:0] HALF_OUT = ACC_W'(64'sd1 <<< 30);
  localparam logic signed [ACC_W-1:0] OUT_TOP  = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [ACC_W-1:0] OUT_BOT  = ACC_W'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  function automatic logic [PCM_W-1:0] round_sat(input logic signed [ACC_W-1:0] sum);
    logic signed [ACC_W-1:0] r;
    r = (sum + HALF_OUT) >>> 31;
    if (r > OUT_TOP) begin
      r = OUT_TOP;
    end else if (r < OUT_BOT) begin
      r = OUT_BOT;
    end
    return r[PCM_W-1:0];
  endfunction

  always_comb begin
    merged.left_out  = round_sat(acc_left);
    merged.right_out = round_sat(acc_right);
  end

endmodule

/* design/three_band_stereo_equalizer_core.sv */
// Three-band stereo equalizer top level: configuration registers, frame sequencer,
// gain refresh, two channel lanes, merge and output register. Depends on tbseq_pkg.
//
// One stereo frame is taken per transaction. Both channels run in their own lane,
// each with one 33x18 multiplier that does four pole updates and three band
// weightings in turn, each a multiply phase then an update phase; the next frame
// is accepted only after the merge state. On the first frame after reset and then
// every GAIN_HOLD frames the three gains are re-derived from the knobs by constant
// reciprocal multiplies in a gain state ahead of the lane sequence. A result waits
// in the output register while the next frame is already taken. Configuration
// writes are always ready and must be made only while no frame is in flight.
module three_band_stereo_equalizer_core import tbseq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  sample_t               sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_GAIN  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_MERGE = 2'd3;

  logic [1:0]         state;
  logic [STEP_W-1:0]  step;
  logic               phase;
  logic [HOLD_W-1:0]  hold_count;
  logic [ALPHA_W-1:0] low_coef;
  logic [ALPHA_W-1:0] high_coef;
  logic [KNOB_W-1:0]  knob [3];
  logic [GAIN_W-1:0]  band_gain [3];

  logic [GAIN_W-1:0]  new_gain [3];
  logic [2:0]         gain_done;
  logic               accept;
  logic               refresh;
  lane_ctrl_t         ctrl;
  logic signed [ACC_W-1:0] acc_left;
  logic signed [ACC_W-1:0] acc_right;
  result_t            merged;

  function automatic logic [KNOB_W-1:0] clamp_knob(input logic [CFG_DATA_W-1:0] d);
    logic [KNOB_W-1:0] k;
    k = d[KNOB_W-1:0];
    if (17'(k) > 17'(KNOB_MAX)) begin
      k = KNOB_W'(KNOB_MAX);
    end
    return k;
  endfunction

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != ST_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign refresh      = accept && (hold_count == '0);

  always_comb begin
    ctrl.load   = accept;
    ctrl.mul_en = (state == ST_RUN) && !phase;
    ctrl.upd_en = (state == ST_RUN) && phase;
    ctrl.step   = step;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      low_coef  <= ALPHA_W'(LOW_COEF_RESET);
      high_coef <= ALPHA_W'(HIGH_COEF_RESET);
      knob[0]   <= KNOB_W'(KNOB_RESET);
      knob[1]   <= KNOB_W'(KNOB_RESET);
      knob[2]   <= KNOB_W'(KNOB_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_COEF:  low_coef  <= cfg_data[ALPHA_W-1:0];
        REG_HIGH_COEF: high_coef <= cfg_data[ALPHA_W-1:0];
        REG_KNOB_LOW:  knob[0]   <= clamp_knob(cfg_data);
        REG_KNOB_MID:  knob[1]   <= clamp_knob(cfg_data);
        REG_KNOB_HIGH: knob[2]   <= clamp_knob(cfg_data);
        default: ;
      endcase
    end
  end

  // frame sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      step         <= STEP_LOW_ONE;
      phase        <= 1'b0;
      hold_count   <= '0;
      result_valid <= 1'b0;
      band_gain[0] <= GAIN_W'(UNITY_GAIN);
      band_gain[1] <= GAIN_W'(UNITY_GAIN);
      band_gain[2] <= GAIN_W'(UNITY_GAIN);
    end else begin
      if ((state == ST_MERGE) && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            step  <= STEP_LOW_ONE;
            phase <= 1'b0;
            if (refresh) begin
              hold_count <= HOLD_W'(GAIN_HOLD - 1);
              state      <= ST_GAIN;
            end else begin
              hold_count <= hold_count - 1'b1;
              state      <= ST_RUN;
            end
          end
        end
        ST_GAIN: begin
          if (&gain_done) begin
            band_gain[0] <= new_gain[0];
            band_gain[1] <= new_gain[1];
            band_gain[2] <= new_gain[2];
            state        <= ST_RUN;
          end
        end
        ST_RUN: begin
          phase <= !phase;
          if (phase) begin
            if (step == STEP_HIGH_BAND) begin
              state <= ST_MERGE;
            end else begin
              step <= step + 1'b1;
            end
          end
        end
        ST_MERGE: begin
          // output register frees up when empty or being taken
          if (!result_valid || !result_stall) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_MERGE) && (!result_valid || !result_stall)) begin
      result <= merged;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_gain
    tbseq_gain u_gain (
      .clk   (clk),
      .rst   (rst),
      .start (refresh),
      .knob  (knob[g]),
      .gain  (new_gain[g]),
      .done  (gain_done[g])
    );
  end

  tbseq_lane u_lane_left (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .sample    (sample.left_in),
    .low_coef  (low_coef),
    .high_coef (high_coef),
    .gain_low  (band_gain[0]),
    .gain_mid  (band_gain[1]),
    .gain_high (band_gain[2]),
    .acc       (acc_left)
  );

  tbseq_lane u_lane_right (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .sample    (sample.right_in),
    .low_coef  (low_coef),
    .high_coef (high_coef),
    .gain_low  (band_gain[0]),
    .gain_mid  (band_gain[1]),
    .gain_high (band_gain[2]),
    .acc       (acc_right)
  );

  tbseq_merge u_merge (
    .acc_left  (acc_left),
    .acc_right (acc_right),
    .merged    (merged)
  );

  a_result_from_merge: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_MERGE)
    else $error("result appeared without a merge");

  a_refresh_enters_gain: assert property (@(posedge clk) disable iff (rst)
    refresh |=> state == ST_GAIN)
    else $error("gain refresh did not start");

  a_gain_units_in_step: assert property (@(posedge clk) disable iff (rst)
    gain_done == 3'b000 || gain_done == 3'b111)
    else $error("gain dividers out of step");

  a_run_ends_in_merge: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && phase && (step == STEP_HIGH_BAND) |=> state == ST_MERGE)
    else $error("lane sequence did not reach merge");

endmodule

/* verif/tb.sv */
// Self-checking testbench for three_band_stereo_equalizer_core: drives stereo frames and
// register writes, predicts every equalized frame and compares it field by field.
// Depends on tbseq_pkg and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tbseq_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 64;
  localparam int BAND_LOW     = 0;
  localparam int BAND_MID     = 1;
  localparam int BAND_HIGH    = 2;
  localparam int CH_LEFT      = 0;
  localparam int CH_RIGHT     = 1;

  // indexes past the register file, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_C = 3'd7;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  sample_valid;
  logic                  sample_stall;
  sample_t               sample;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // mirror of the equalizer state
  logic [ALPHA_W-1:0]        alpha_low;
  logic [ALPHA_W-1:0]        alpha_high;
  logic [KNOB_W-1:0]         knob_pos [3];
  logic [GAIN_W-1:0]         gain_q15 [3];
  logic signed [STATE_W-1:0] lo_pole1 [2];
  logic signed [STATE_W-1:0] lo_pole2 [2];
  logic signed [STATE_W-1:0] hi_pole1 [2];
  logic signed [STATE_W-1:0] hi_pole2 [2];
  logic [HOLD_W-1:0]         frames_to_refresh;

  result_t     expected_frames [$];
  reg_write_t  pending_writes [$];
  logic [PCM_W-1:0] walk_level [2];
  int          errors = 0;
  int          rx_hold_cycles = 0;
  bit          idle_enabled = 1'b1;
  int unsigned cycle_count = 0;

  three_band_stereo_equalizer_core dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL three_band_stereo_equalizer_core");
      $finish;
    end
  end

  // ---------------------------------------------------------------- prediction

  function automatic void reset_mirror();
    alpha_low = ALPHA_W'(LOW_COEF_RESET);
    alpha_high = ALPHA_W'(HIGH_COEF_RESET);
    for (int b = 0; b < 3; b++) begin
      knob_pos[b] = KNOB_W'(KNOB_RESET);
      gain_q15[b] = GAIN_W'(UNITY_GAIN);
    end
    for (int c = 0; c < 2; c++) begin
      lo_pole1[c] = '0;
      lo_pole2[c] = '0;
      hi_pole1[c] = '0;
      hi_pole2[c] = '0;
      walk_level[c] = '0;
    end
    frames_to_refresh = '0;
  endfunction

  function automatic void mirror_write(input reg_write_t w);
    logic [KNOB_W-1:0] k;
    k = w.data[KNOB_W-1:0];
    if (k > KNOB_MAX) k = KNOB_W'(KNOB_MAX);
    case (w.idx)
      REG_LOW_COEF:  alpha_low = w.data[ALPHA_W-1:0];
      REG_HIGH_COEF: alpha_high = w.data[ALPHA_W-1:0];
      REG_KNOB_LOW:  knob_pos[BAND_LOW] = k;
      REG_KNOB_MID:  knob_pos[BAND_MID] = k;
      REG_KNOB_HIGH: knob_pos[BAND_HIGH] = k;
      default: ;
    endcase
  endfunction

  // knob to Q2.15 gain, rounded half up on both sides of center
  function automatic logic [GAIN_W-1:0] knob_gain(input logic [KNOB_W-1:0] k);
    longint kv, c, m;
    kv = k;
    c = KNOB_CENTER;
    m = KNOB_MAX;
    if (kv <= c || m <= c) return GAIN_W'((kv * 32768 + c / 2) / c);
    return GAIN_W'(32768 + ((kv - c) * 32768 + (m - c) / 2) / (m - c));
  endfunction

  function automatic logic signed [STATE_W-1:0] one_pole(
    input logic signed [STATE_W-1:0] y,
    input longint target,
    input logic [ALPHA_W-1:0] a
  );
    longint av, prod, moved;
    av = a;
    prod = (target - longint'(y)) * av;
    moved = longint'(y) + ((prod + 32768) >>> 16);
    if (moved > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (moved < -64'sh8000_0000) return 32'h8000_0000;
    return moved[STATE_W-1:0];
  endfunction

  function automatic logic [PCM_W-1:0] eq_channel(input logic signed [PCM_W-1:0] s,
                                                  input int ch);
    longint x, lo, mid, hi, acc, r, top, bot;
    x = longint'(s) * 65536;
    lo_pole1[ch] = one_pole(lo_pole1[ch], x, alpha_low);
    lo_pole2[ch] = one_pole(lo_pole2[ch], lo_pole1[ch], alpha_low);
    hi_pole1[ch] = one_pole(hi_pole1[ch], x, alpha_high);
    hi_pole2[ch] = one_pole(hi_pole2[ch], hi_pole1[ch], alpha_high);
    lo = lo_pole2[ch];
    hi = x - longint'(hi_pole2[ch]);
    mid = x - lo - hi;
    acc = lo * longint'(gain_q15[BAND_LOW]) + mid * longint'(gain_q15[BAND_MID]) +
          hi * longint'(gain_q15[BAND_HIGH]);
    r = (acc + 64'sd1073741824) >>> 31;
    top = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    bot = -(64'sd1 <<< (SAMPLE_BITS - 1));
    if (r > top) r = top;
    if (r < bot) r = bot;
    return r[PCM_W-1:0];
  endfunction

  function automatic result_t equalize_frame(input sample_t s);
    result_t f;
    if (frames_to_refresh == '0) begin
      for (int b = 0; b < 3; b++) gain_q15[b] = knob_gain(knob_pos[b]);
      frames_to_refresh = HOLD_W'(GAIN_HOLD);
    end
    frames_to_refresh = frames_to_refresh - 1'b1;
    f.left_out = eq_channel(s.left_in, CH_LEFT);
    f.right_out = eq_channel(s.right_in, CH_RIGHT);
    return f;
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void note_error(input string what, input result_t want,
                                     input result_t got);
    if (errors < 10)
      $display("mismatch on %s at cycle %0d: expected L=%0d R=%0d, got L=%0d R=%0d",
               what, cycle_count, want.left_out, want.right_out,
               got.left_out, got.right_out);
    errors++;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_frames.size() == 0) begin
        note_error("frame with nothing pending", '0, result);
      end else begin
        want = expected_frames.pop_front();
        if (result.left_out !== want.left_out) note_error("left_out", want, result);
        if (result.right_out !== want.right_out) note_error("right_out", want, result);
      end
    end
  end

  // result side stalls: random bursts, or one long hold-off on request
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        result_stall <= 1'b1;
        while (rx_hold_cycles > 0) begin
          @(posedge clk);
          rx_hold_cycles--;
        end
        result_stall <= 1'b0;
      end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- driving

  task automatic send_frame(input logic [PCM_W-1:0] l, input logic [PCM_W-1:0] r);
    sample_t s;
    s.left_in = l;
    s.right_in = r;
    sample <= s;
    sample_valid <= 1'b1;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    expected_frames.push_back(equalize_frame(s));
    if (idle_enabled && $urandom_range(0, 7) == 0) begin
      sample_valid <= 1'b0;
      sample <= sample_t'($urandom);
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic void queue_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    reg_write_t w;
    w.idx = idx;
    w.data = data;
    pending_writes.push_back(w);
  endfunction

  // valid stays high across back-to-back writes
  task automatic flush_writes();
    reg_write_t w;
    while (pending_writes.size() != 0) begin
      w = pending_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data <= w.data;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      mirror_write(w);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    sample_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_alpha();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return CFG_DATA_W'($urandom_range(1, 512));
      3: return CFG_DATA_W'($urandom_range(LOW_COEF_RESET - 2000, HIGH_COEF_RESET + 2000));
      default: return CFG_DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_knob();
    case ($urandom_range(0, 6))
      0: return 16'd0;
      1: return 16'd4095;
      2: return CFG_DATA_W'(KNOB_CENTER + $urandom_range(0, 64) - 32);
      3: return CFG_DATA_W'($urandom_range(0, 65535));  // upper bits beyond the knob width
      default: return CFG_DATA_W'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic logic [PCM_W-1:0] pick_pcm(input int ch);
    case ($urandom_range(0, 9))
      0, 1, 2: return PCM_W'($urandom_range(0, 65535));
      3: return 16'h7FFF;
      4: return 16'h8000;
      5: return PCM_W'($urandom_range(0, 511) - 256);
      default: begin
        // slow random walk keeps the low band busy
        walk_level[ch] = walk_level[ch] + PCM_W'($urandom_range(0, 4096) - 2048);
        return walk_level[ch];
      end
    endcase
  endfunction

  task automatic random_settings();
    queue_write(REG_LOW_COEF, pick_alpha());
    queue_write(REG_HIGH_COEF, pick_alpha());
    queue_write(REG_KNOB_LOW, pick_knob());
    queue_write(REG_KNOB_MID, pick_knob());
    queue_write(REG_KNOB_HIGH, pick_knob());
    if ($urandom_range(0, 3) == 0)
      queue_write(CFG_IDX_W'($urandom_range(REG_SPARE_A, REG_SPARE_C)),
                  CFG_DATA_W'($urandom_range(0, 65535)));
    flush_writes();
  endtask

  task automatic send_random(input int count);
    repeat (count) send_frame(pick_pcm(CH_LEFT), pick_pcm(CH_RIGHT));
  endtask

  // ---------------------------------------------------------------- tests

  // written before the first frame so the first gain refresh picks up full boost
  task automatic test_full_boost();
    queue_write(REG_LOW_COEF, 16'hFFFF);
    queue_write(REG_HIGH_COEF, 16'hFFFF);
    queue_write(REG_KNOB_LOW, 16'hFFFF);
    queue_write(REG_KNOB_MID, 16'hFFFF);
    queue_write(REG_KNOB_HIGH, 16'hFFFF);
    queue_write(REG_SPARE_A, 16'hFFFF);
    queue_write(REG_SPARE_C, 16'h1234);
    flush_writes();
    repeat (3) begin
      send_frame(16'h7FFF, 16'h8000);
      send_frame(16'h8000, 16'h7FFF);
    end
    wait_drained();
  endtask

  // zero coefficient freezes every filter stage
  task automatic test_frozen_filters();
    queue_write(REG_LOW_COEF, 16'h0000);
    queue_write(REG_HIGH_COEF, 16'h0000);
    queue_write(REG_KNOB_LOW, 16'h0000);
    queue_write(REG_KNOB_MID, 16'hF800);
    queue_write(REG_KNOB_HIGH, 16'h0FFF);
    queue_write(REG_SPARE_B, 16'hA5A5);
    flush_writes();
    send_frame(16'h0000, 16'h0000);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h5555, 16'hAAAA);
    send_frame(16'hFFFF, 16'h0001);
    wait_drained();
  endtask

  task automatic test_sample_extremes();
    queue_write(REG_LOW_COEF, CFG_DATA_W'(LOW_COEF_RESET));
    queue_write(REG_HIGH_COEF, CFG_DATA_W'(HIGH_COEF_RESET));
    queue_write(REG_KNOB_LOW, CFG_DATA_W'(KNOB_RESET));
    queue_write(REG_KNOB_MID, CFG_DATA_W'(KNOB_RESET));
    queue_write(REG_KNOB_HIGH, CFG_DATA_W'(KNOB_RESET));
    flush_writes();
    send_frame(16'h0000, 16'h0000);
    send_frame(16'h7FFF, 16'h7FFF);
    send_frame(16'h8000, 16'h8000);
    send_frame(16'hAAAA, 16'h5555);
    send_frame(16'h0001, 16'hFFFF);
    send_frame(16'h8000, 16'h7FFF);
    wait_drained();
  endtask

  // long receiver hold-off fills the output register and backs up the input
  task automatic test_backpressure();
    rx_hold_cycles = 400;
    send_random(12);
    wait_drained();
  endtask

  task automatic test_random_phases();
    repeat (8) begin
      random_settings();
      send_random(170);
      wait_drained();
    end
  endtask

  task automatic test_streaming_tail();
    idle_enabled = 1'b0;
    random_settings();
    send_random(300);
    wait_drained();
  endtask

  initial begin
    rst <= 1'b1;
    sample_valid <= 1'b0;
    sample <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    reset_mirror();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_full_boost();
    test_frozen_filters();
    test_sample_extremes();
    test_backpressure();
    test_random_phases();
    test_streaming_tail();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_frames.size() == 0) begin
      $display("PASS three_band_stereo_equalizer_core");
    end else begin
      $display("FAIL three_band_stereo_equalizer_core");
    end
    $finish;
  end

endmodule
